### hw/rtl/fcpa_pkg.sv
// Shared types, codes and defaults for the fixed cell pool allocator.
package fcpa_pkg;

    // Default number of cells in the pool.
    localparam int POOL_CELLS_DEF = 64;

    // Widths fixed by the item and register layouts.
    localparam int ADDR_W     = 48;
    localparam int CBYTES_W   = 16;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;

    // Reset value of the cell size register.
    localparam logic [CBYTES_W-1:0] CELL_BYTES_RST = CBYTES_W'(16);

    // Request kinds.
    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_POOL_EMPTY = 2'd1,
        ST_FREED      = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 1'b0,
        CFG_CELL_BYTES   = 1'b1
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOOKUP,
        SEQ_ADDRESS
    } t_seq_state;

    // One request item.
    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  cell_index;
    } t_req;

    // One result item.
    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    granted_index;
        logic [ADDR_W-1:0]   granted_address;
        logic [COUNT_W-1:0]  cells_free;
    } t_rsp;

endpackage

### hw/rtl/fcpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_store[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/fcpa_addr_unit.sv
// Cell address unit: registered index times cell size, then add of the pool base.
module fcpa_addr_unit #(
    parameter int IW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [IW-1:0]                 i_index,
    input  logic [fcpa_pkg::CBYTES_W-1:0] i_cell_bytes,
    input  logic [fcpa_pkg::ADDR_W-1:0]   i_base,
    output logic [fcpa_pkg::ADDR_W-1:0]   o_address
);
    import fcpa_pkg::*;

    localparam int PW = IW + CBYTES_W;

    logic [PW-1:0] r_prod;
    logic [PW-1:0] n_prod;

    // Product of the cell index and the cell size.
    always_comb begin
        n_prod = r_prod;
        if (i_load) begin
            n_prod = PW'(i_index) * PW'(i_cell_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // The address wraps modulo the address width.
    assign o_address = i_base + ADDR_W'(r_prod);

endmodule

### hw/rtl/fixed_cell_pool_allocator.sv
// Top level of the fixed cell pool allocator: sequencer, free stack and allocation map.
//
// Usage: a request item (allocate, or free by cell index) is taken at a clock
// edge where start is high and busy is low. Exactly one result item follows,
// shown on o_rsp for a single cycle while o_done is high; it cannot be held
// off. A free request, or an allocate on an empty pool, takes its result from
// the lookup state; a successful allocate goes on to the address state, which
// waits for the registered index-times-size product ahead of the base add. The
// free stack and the allocation map are single-port-read RAMs with registered
// reads, and each request makes one read and at most one write to each, so a
// new item is not taken before the last one has its result. busy is already
// low in the cycle that shows the result, so a new request may be given then.
// Reset empties the allocation map and sets the free stack to hand cells out
// in index order; no clearing pass is needed, a high-water mark of cells ever
// handed out tells which RAM entries hold real data. Reset also sets the base
// address to zero and the cell size to 16 bytes. Configuration writes through
// i_cfg_we, i_cfg_idx and i_cfg_data take effect at once and belong in idle time.
module fixed_cell_pool_allocator #(
    parameter int POOL_CELLS = fcpa_pkg::POOL_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fcpa_pkg::t_req                 i_req,
    output logic                           o_done,
    output fcpa_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fcpa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import fcpa_pkg::*;

    localparam int IW = $clog2(POOL_CELLS);
    localparam int CW = $clog2(POOL_CELLS + 1);
    localparam logic [CW-1:0] CELLS_C = CW'(POOL_CELLS);

    t_seq_state           r_state, n_state;
    logic [CW-1:0]        r_depth, n_depth;
    logic [CW-1:0]        r_hwm, n_hwm;
    t_func                r_func, n_func;
    logic [IDX_W-1:0]     r_req_idx, n_req_idx;
    logic [IW-1:0]        r_cell, n_cell;
    logic                 r_done, n_done;
    t_rsp                 r_rsp, n_rsp;
    logic [ADDR_W-1:0]    r_base;
    logic [CBYTES_W-1:0]  r_cell_bytes;

    logic                 accept;
    logic [CW-1:0]        top;
    logic                 top_fresh;
    logic                 req_in_pool;
    logic [IW-1:0]        alloc_cell;

    logic                 stk_we;
    logic [IW-1:0]        stk_waddr;
    logic [IW-1:0]        stk_wdata;
    logic [IW-1:0]        stk_rdata;
    logic                 map_we;
    logic [IW-1:0]        map_waddr;
    logic                 map_wdata;
    logic                 map_rdata;
    logic                 addr_load;
    logic [ADDR_W-1:0]    cell_address;

    assign accept = start && (r_state == SEQ_IDLE);
    assign busy   = (r_state != SEQ_IDLE);

    // The stack grows downward; its top entry sits at POOL_CELLS - depth.
    assign top = CELLS_C - r_depth;

    // Entries at or above the high-water mark were never written; top is used instead.
    assign top_fresh  = (top >= r_hwm);
    assign alloc_cell = top_fresh ? IW'(top) : stk_rdata;
    assign req_in_pool = (32'(r_req_idx) < 32'(POOL_CELLS)) && (CW'(r_req_idx) < r_hwm);

    // Free stack: read at the current top while idle, pushed by a successful free.
    fcpa_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (IW'(top)),
        .o_rdata (stk_rdata)
    );

    // Allocation map: one bit per cell, read at the requested index.
    fcpa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_CELLS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (IW'(i_req.cell_index)),
        .o_rdata (map_rdata)
    );

    // Address of the granted cell.
    fcpa_addr_unit #(
        .IW (IW)
    ) u_addr (
        .i_clk        (i_clk),
        .i_load       (addr_load),
        .i_index      (alloc_cell),
        .i_cell_bytes (r_cell_bytes),
        .i_base       (r_base),
        .o_address    (cell_address)
    );

    // Sequencer: next state, RAM writes and the result item.
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_hwm     = r_hwm;
        n_func    = r_func;
        n_req_idx = r_req_idx;
        n_cell    = r_cell;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        stk_we    = 1'b0;
        stk_waddr = IW'(top - CW'(1));
        stk_wdata = IW'(r_req_idx);
        map_we    = 1'b0;
        map_waddr = alloc_cell;
        map_wdata = 1'b1;
        addr_load = 1'b0;

        case (r_state)
            SEQ_IDLE: begin
                if (accept) begin
                    n_func    = i_req.func;
                    n_req_idx = i_req.cell_index;
                    n_state   = SEQ_LOOKUP;
                end
            end

            SEQ_LOOKUP: begin
                n_rsp.granted_index   = '0;
                n_rsp.granted_address = '0;
                if (r_func == FUNC_ALLOC) begin
                    if (r_depth == '0) begin
                        n_rsp.status     = ST_POOL_EMPTY;
                        n_rsp.cells_free = COUNT_W'(r_depth);
                        n_done           = 1'b1;
                        n_state          = SEQ_IDLE;
                    end else begin
                        // Pop the top cell and mark it allocated.
                        map_we    = 1'b1;
                        addr_load = 1'b1;
                        n_cell    = alloc_cell;
                        n_depth   = r_depth - CW'(1);
                        if (top_fresh) begin
                            n_hwm = r_hwm + CW'(1);
                        end
                        n_state = SEQ_ADDRESS;
                    end
                end else begin
                    if (req_in_pool && map_rdata && (r_depth < CELLS_C)) begin
                        // Clear the map bit and push the cell on the stack.
                        map_we           = 1'b1;
                        map_waddr        = IW'(r_req_idx);
                        map_wdata        = 1'b0;
                        stk_we           = 1'b1;
                        n_depth          = r_depth + CW'(1);
                        n_rsp.status     = ST_FREED;
                        n_rsp.cells_free = COUNT_W'(r_depth + CW'(1));
                    end else begin
                        n_rsp.status     = ST_NOT_FOUND;
                        n_rsp.cells_free = COUNT_W'(r_depth);
                    end
                    n_done  = 1'b1;
                    n_state = SEQ_IDLE;
                end
            end

            SEQ_ADDRESS: begin
                n_rsp.status          = ST_ALLOCATED;
                n_rsp.granted_index   = IDX_W'(r_cell);
                n_rsp.granted_address = cell_address;
                n_rsp.cells_free      = COUNT_W'(r_depth);
                n_done                = 1'b1;
                n_state               = SEQ_IDLE;
            end

            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_depth <= CELLS_C;
            r_hwm   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_hwm   <= n_hwm;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_req_idx <= n_req_idx;
        r_cell    <= n_cell;
        r_rsp     <= n_rsp;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_cell_bytes <= CELL_BYTES_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_BASE_ADDRESS: r_base       <= i_cfg_data;
                CFG_CELL_BYTES:   r_cell_bytes <= i_cfg_data[CBYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

### hw/rtl/fcpa_checker.sv
// Port-level checks on the fixed cell pool allocator, bound to its top level.
module fcpa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input fcpa_pkg::t_rsp o_rsp
);
    import fcpa_pkg::*;

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // The block only becomes busy by accepting an item.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // A result item is shown only once the work on it has finished.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result item shown while busy");

    // Index and address are zero unless a cell was granted.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_ALLOCATED)) |->
            ((o_rsp.granted_index == '0) && (o_rsp.granted_address == '0)))
        else $error("granted fields not zero on a non-allocation result");

    // An empty pool reports no free cells.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_POOL_EMPTY)) |-> (o_rsp.cells_free == '0))
        else $error("pool empty reported with free cells");

endmodule

bind fixed_cell_pool_allocator fcpa_checker u_fcpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
